@@ rtl/core/cct_pkg.sv @@
// Package for the cycle counter timebase: shared types, commands and constants.
// Used by cct_div, cct_ctrl, cct_dp and cycle_counter_timebase_top; depends on nothing.
package cct_pkg;

    localparam int unsigned SAMPLE_W  = 32;
    localparam int unsigned EXT_W     = 64;
    localparam int unsigned MHZ_W     = 13;
    localparam int unsigned SEC_W     = 45;
    localparam int unsigned FRAC_W    = 10;
    localparam int unsigned DIVISOR_W = 33;
    localparam int unsigned PER_MS_W  = 23;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned MUL_A_W   = 23;

    localparam logic [MHZ_W-1:0]   CLOCK_MHZ_RESET = 13'd168;
    localparam logic [19:0]        SEC_US          = 20'd1000000;
    localparam logic [FRAC_W-1:0]  MS_US           = 10'd1000;
    localparam logic [COUNT_W-1:0] SEC_STEPS       = 7'd64;
    localparam logic [COUNT_W-1:0] FRAC_STEPS      = 7'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEC_START,
        ST_SEC_RUN,
        ST_MS_START,
        ST_MS_RUN,
        ST_US_START,
        ST_US_RUN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_SEC,
        DIV_MS,
        DIV_US
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_step;
        div_sel_t div_sel;
        logic     save_sec;
        logic     save_ms;
        logic     save_us;
        logic     mul_lo;
        logic     mul_hi;
        logic     finish;
    } cct_cmd_t;

    typedef struct packed {
        logic div_done;
    } cct_stat_t;

endpackage

@@ rtl/core/cct_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the three divisions.
// Depends on cct_pkg for widths.
module cct_div
    import cct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 step,
    input  logic [DIVISOR_W-1:0] init_rem,
    input  logic [EXT_W-1:0]     init_quo,
    input  logic [DIVISOR_W-1:0] divisor,
    input  logic [COUNT_W-1:0]   steps,
    output logic [EXT_W-1:0]     quotient,
    output logic [DIVISOR_W-1:0] remainder,
    output logic                 done
);

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [EXT_W-1:0]     quo_reg, quo_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W+1:0] diff;

    assign shifted = {rem_reg, quo_reg[EXT_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};

    always_comb
    begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        count_next = count_reg;
        if (start)
        begin
            rem_next   = init_rem;
            quo_next   = init_quo;
            count_next = steps;
        end
        else if (step)
        begin
            count_next = count_reg - 1'b1;
            if (!diff[DIVISOR_W+1])
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[EXT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVISOR_W-1:0];
                quo_next = {quo_reg[EXT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = (count_reg == '0);

    // A step with no quotient bits left would corrupt the result.
    assert property (@(posedge clk) disable iff (!rst_n) step |-> count_reg != '0)
        else $error("cct_div: step issued with no bits left");

endmodule

@@ rtl/core/cct_ctrl.sv @@
// Controller state machine for the cycle counter timebase.
// Sequences the datapath through commands; depends on cct_pkg.
module cct_ctrl
    import cct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  cct_stat_t stat,
    output cct_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_SEC_START;
            ST_SEC_START: state_next = ST_SEC_RUN;
            ST_SEC_RUN:   if (stat.div_done) state_next = ST_MS_START;
            ST_MS_START:  state_next = ST_MS_RUN;
            ST_MS_RUN:    if (stat.div_done) state_next = ST_US_START;
            ST_US_START:  state_next = ST_US_RUN;
            ST_US_RUN:    if (stat.div_done) state_next = ST_MUL_LO;
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SEC_START:
            begin
                cmd.div_sel   = DIV_SEC;
                cmd.div_start = 1'b1;
            end
            ST_SEC_RUN:
            begin
                cmd.div_sel  = DIV_SEC;
                cmd.div_step = !stat.div_done;
                cmd.save_sec = stat.div_done;
            end
            ST_MS_START:
            begin
                cmd.div_sel   = DIV_MS;
                cmd.div_start = 1'b1;
            end
            ST_MS_RUN:
            begin
                cmd.div_sel  = DIV_MS;
                cmd.div_step = !stat.div_done;
                cmd.save_ms  = stat.div_done;
            end
            ST_US_START:
            begin
                cmd.div_sel   = DIV_US;
                cmd.div_start = 1'b1;
            end
            ST_US_RUN:
            begin
                cmd.div_sel  = DIV_US;
                cmd.div_step = !stat.div_done;
                cmd.save_us  = stat.div_done;
            end
            ST_MUL_LO:    cmd.mul_lo = 1'b1;
            ST_MUL_HI:    cmd.mul_hi = 1'b1;
            ST_DONE:      cmd.finish = out_free;
            default:      cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && !in_stall) |=> in_stall)
        else $error("cct_ctrl: second request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> out_valid)
        else $error("cct_ctrl: finished result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEC_RUN && stat.div_done) |=> state_reg == ST_MS_START)
        else $error("cct_ctrl: seconds division did not hand over");

endmodule

@@ rtl/core/cct_dp.sv @@
// Datapath for the cycle counter timebase: wrap tracking, divisors, shared divider,
// timeline multiplier and result registers. Depends on cct_pkg and cct_div.
module cct_dp
    import cct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [MHZ_W-1:0]    clock_mhz,
    input  logic [SAMPLE_W-1:0] counter_sample,
    input  cct_cmd_t            cmd,
    output cct_stat_t           stat,
    output logic [EXT_W-1:0]    extended_cycles,
    output logic [SEC_W-1:0]    seconds,
    output logic [FRAC_W-1:0]   milliseconds,
    output logic [FRAC_W-1:0]   microseconds,
    output logic [EXT_W-1:0]    timeline_us,
    output logic                wrapped
);

    logic [MHZ_W-1:0]     clock_mhz_reg;
    logic [SAMPLE_W-1:0]  last_sample_reg;
    logic [SAMPLE_W-1:0]  wrap_count_reg, wrap_count_next;
    logic [EXT_W-1:0]     ext_reg;
    logic                 wrap_reg;
    logic [MHZ_W-1:0]     mhz_reg;
    logic [DIVISOR_W-1:0] per_sec_reg;
    logic [PER_MS_W-1:0]  per_ms_reg;
    logic [SEC_W-1:0]     secs_reg;
    logic [FRAC_W-1:0]    ms_reg;
    logic [FRAC_W-1:0]    us_reg;
    logic [EXT_W-1:0]     acc_reg;

    logic [EXT_W-1:0]     out_ext_reg;
    logic [SEC_W-1:0]     out_secs_reg;
    logic [FRAC_W-1:0]    out_ms_reg;
    logic [FRAC_W-1:0]    out_us_reg;
    logic [EXT_W-1:0]     out_timeline_reg;
    logic                 out_wrap_reg;

    logic                 wrap_now;
    logic [MHZ_W-1:0]     mhz_eff;
    logic [DIVISOR_W-1:0] div_init_rem;
    logic [EXT_W-1:0]     div_init_quo;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [COUNT_W-1:0]   div_steps;
    logic [EXT_W-1:0]     div_quo;
    logic [DIVISOR_W-1:0] div_rem;
    logic                 div_done;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_A_W+19:0]  mul_p;
    logic [19:0]          ms_scaled;

    assign wrap_now        = counter_sample < last_sample_reg;
    assign wrap_count_next = wrap_count_reg + {{(SAMPLE_W-1){1'b0}}, wrap_now};
    assign mhz_eff         = (clock_mhz_reg == '0) ? {{(MHZ_W-1){1'b0}}, 1'b1} : clock_mhz_reg;

    // The seconds quotient takes all 64 bits; the later quotients are below 1000,
    // so the remainder starts from the upper bits and only ten bits are shifted in.
    always_comb
    begin
        case (cmd.div_sel)
            DIV_SEC:
            begin
                div_init_rem = '0;
                div_init_quo = ext_reg;
                div_divisor  = per_sec_reg;
                div_steps    = SEC_STEPS;
            end
            DIV_MS:
            begin
                div_init_rem = {{FRAC_W{1'b0}}, div_rem[DIVISOR_W-1:FRAC_W]};
                div_init_quo = {div_rem[FRAC_W-1:0], {(EXT_W-FRAC_W){1'b0}}};
                div_divisor  = {{(DIVISOR_W-PER_MS_W){1'b0}}, per_ms_reg};
                div_steps    = FRAC_STEPS;
            end
            DIV_US:
            begin
                div_init_rem = {{FRAC_W{1'b0}}, div_rem[DIVISOR_W-1:FRAC_W]};
                div_init_quo = {div_rem[FRAC_W-1:0], {(EXT_W-FRAC_W){1'b0}}};
                div_divisor  = {{(DIVISOR_W-MHZ_W){1'b0}}, mhz_reg};
                div_steps    = FRAC_STEPS;
            end
            default:
            begin
                div_init_rem = '0;
                div_init_quo = ext_reg;
                div_divisor  = per_sec_reg;
                div_steps    = SEC_STEPS;
            end
        endcase
    end

    cct_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .init_rem  (div_init_rem),
        .init_quo  (div_init_quo),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign stat.div_done = div_done;

    assign mul_a     = cmd.mul_hi ? {1'b0, secs_reg[SEC_W-1:MUL_A_W]} : secs_reg[MUL_A_W-1:0];
    assign mul_p     = mul_a * SEC_US;
    assign ms_scaled = ms_reg * MS_US;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_mhz_reg   <= CLOCK_MHZ_RESET;
            last_sample_reg <= '0;
            wrap_count_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                clock_mhz_reg <= clock_mhz;
            end
            if (cmd.load)
            begin
                last_sample_reg <= counter_sample;
                wrap_count_reg  <= wrap_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ext_reg     <= {wrap_count_next, counter_sample};
            wrap_reg    <= wrap_now;
            mhz_reg     <= mhz_eff;
            per_sec_reg <= {{(DIVISOR_W-MHZ_W){1'b0}}, mhz_eff}
                           * {{(DIVISOR_W-20){1'b0}}, SEC_US};
            per_ms_reg  <= {{(PER_MS_W-MHZ_W){1'b0}}, mhz_eff}
                           * {{(PER_MS_W-FRAC_W){1'b0}}, MS_US};
        end
        if (cmd.save_sec)
        begin
            secs_reg <= div_quo[SEC_W-1:0];
        end
        if (cmd.save_ms)
        begin
            ms_reg <= div_quo[FRAC_W-1:0];
        end
        if (cmd.save_us)
        begin
            us_reg <= div_quo[FRAC_W-1:0];
        end
        if (cmd.mul_lo)
        begin
            acc_reg <= {{(EXT_W-MUL_A_W-20){1'b0}}, mul_p};
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= acc_reg + {mul_p[EXT_W-MUL_A_W-1:0], {MUL_A_W{1'b0}}};
        end
        if (cmd.finish)
        begin
            out_ext_reg      <= ext_reg;
            out_secs_reg     <= secs_reg;
            out_ms_reg       <= ms_reg;
            out_us_reg       <= us_reg;
            out_timeline_reg <= acc_reg + {{(EXT_W-20){1'b0}}, ms_scaled}
                                        + {{(EXT_W-FRAC_W){1'b0}}, us_reg};
            out_wrap_reg     <= wrap_reg;
        end
    end

    assign extended_cycles = out_ext_reg;
    assign seconds         = out_secs_reg;
    assign milliseconds    = out_ms_reg;
    assign microseconds    = out_us_reg;
    assign timeline_us     = out_timeline_reg;
    assign wrapped         = out_wrap_reg;

    // Milliseconds come from a remainder below one second and must stay below 1000.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.save_ms |=> ms_reg < MS_US)
        else $error("cct_dp: millisecond quotient out of range");

endmodule

@@ rtl/core/cycle_counter_timebase_top.sv @@
// A request runs the seconds, milliseconds and microseconds divisions on the
// shared one-bit-per-cycle divider (64 steps for seconds, 10 for each other),
// then two multiply steps. A new request waits until the last has finished.
// A finished result waits in the output register while the next request runs.
// Reset (rst_n, asynchronous) clears the wrap count and last sample and sets
// clock_mhz to 168. Depends on cct_pkg, cct_ctrl and cct_dp.
module cycle_counter_timebase_top
    import cct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MHZ_W-1:0]    clock_mhz,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] counter_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [EXT_W-1:0]    extended_cycles,
    output logic [SEC_W-1:0]    seconds,
    output logic [FRAC_W-1:0]   milliseconds,
    output logic [FRAC_W-1:0]   microseconds,
    output logic [EXT_W-1:0]    timeline_us,
    output logic                wrapped
);

    cct_cmd_t  cmd;
    cct_stat_t stat;

    assign cfg_ready = 1'b1;

    cct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cct_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_valid && cfg_ready),
        .clock_mhz       (clock_mhz),
        .counter_sample  (counter_sample),
        .cmd             (cmd),
        .stat            (stat),
        .extended_cycles (extended_cycles),
        .seconds         (seconds),
        .milliseconds    (milliseconds),
        .microseconds    (microseconds),
        .timeline_us     (timeline_us),
        .wrapped         (wrapped)
    );

endmodule
